[rtl/sqvs_pkg.sv]
// Shared types, constants and helper functions for the sprite quad vertex setup.
package sqvs_pkg;

   // CORDIC iteration count; anything above the atan table length acts as the table length
   localparam int CORDIC_STEPS    = 16;
   localparam int ATAN_LEN        = 24;
   localparam int CORDIC_N        = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
   localparam int STEPS_PER_STAGE = 2;
   localparam int CORDIC_STG      = (CORDIC_N + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DIV_QBITS       = 17;
   localparam int DIV_STG         = (DIV_QBITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int ITER_STAGES     = (CORDIC_STG > DIV_STG) ? CORDIC_STG : DIV_STG;

   localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;
   localparam logic signed [31:0] ANG_EIGHTH = 32'sh2000_0000;

   localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // register indexes of the configuration port
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CCW_WINDING  = 2'd2;

   localparam logic [1:0]  LAST_CORNER = 2'd3;
   localparam logic [16:0] TEX_ONE     = 17'd65536;

   typedef struct packed {
      logic [11:0]        src_left;
      logic [11:0]        src_top;
      logic [12:0]        src_width;
      logic [12:0]        src_height;
      logic signed [23:0] offset_x;
      logic signed [23:0] offset_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [23:0] pivot_x;
      logic signed [23:0] pivot_y;
      logic [15:0]        turn_angle;
   } req_type;

   // payload carried through the iteration stages
   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [1:0]         quad;
      logic               rot;
      logic [3:0][29:0]   rem;
      logic [3:0][16:0]   qt;
      logic [3:0]         zero;
      logic [3:0]         ovf;
      logic [12:0]        div_u;
      logic [12:0]        div_v;
      logic signed [30:0] x_l;
      logic signed [30:0] x_r;
      logic signed [30:0] y_t;
      logic signed [30:0] y_b;
      logic signed [31:0] tx_l;
      logic signed [31:0] tx_r;
      logic signed [31:0] ty_t;
      logic signed [31:0] ty_b;
      logic signed [23:0] px;
      logic signed [23:0] py;
   } itm_type;

   typedef struct packed {
      logic [3:0][23:0] vx;
      logic [3:0][23:0] vy;
      logic [3:0][16:0] tu;
      logic [3:0][16:0] tv;
   } quad_type;

   function automatic logic signed [31:0] atan_at(input int i);
      if (i < ATAN_LEN) return $signed(ATAN_TURNS[i]);
      return 32'sd0;
   endfunction

   function automatic logic [23:0] sat24(input logic signed [34:0] v);
      if (v > 35'sd8388607) return 24'h7FFFFF;
      if (v < -35'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

endpackage

[rtl/sqvs_front.sv]
// Input register, scale products, texture dividends and CORDIC start values.
module sqvs_front import sqvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_v,
   input  req_type     in_d,
   input  logic [12:0] img_w,
   input  logic [12:0] img_h,
   output logic        out_v,
   output itm_type     out_d
);

   typedef struct packed {
      logic signed [29:0] prod_w;
      logic signed [29:0] prod_h;
      logic signed [23:0] ox;
      logic signed [23:0] oy;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic               sx_neg;
      logic               sy_neg;
      logic [3:0][29:0]   rem;
      logic [3:0]         zero;
      logic [12:0]        div_u;
      logic [12:0]        div_v;
      logic signed [31:0] cz;
      logic [1:0]         quad;
      logic               rot;
   } fs1_type;

   req_type s0_ff;
   logic    s0_v_ff;
   fs1_type s1_ff, s1_in;
   logic    s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= in_v;
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= in_d;
         s1_ff <= s1_in;
      end
   end

   always_comb begin
      logic [12:0]        du;
      logic [12:0]        dv;
      logic [12:0]        dsel;
      logic signed [14:0] num [4];
      logic [31:0]        ang_r;
      du = (img_w == 13'd0) ? 13'd1 : img_w;
      dv = (img_h == 13'd0) ? 13'd1 : img_h;
      num[0] = $signed({3'b000, s0_ff.src_left});
      num[1] = $signed({1'b0, 14'(s0_ff.src_left) + 14'(s0_ff.src_width)});
      num[2] = $signed({2'b00, dv}) - $signed({3'b000, s0_ff.src_top});
      num[3] = num[2] - $signed({2'b00, s0_ff.src_height});
      s1_in.div_u = du;
      s1_in.div_v = dv;
      for (int n = 0; n < 4; n++) begin
         dsel = (n < 2) ? du : dv;
         s1_in.zero[n] = num[n][14] | (num[n] == 15'sd0);
         s1_in.rem[n]  = {num[n][13:0], 16'h0000} + {18'd0, dsel[12:1]};
      end
      s1_in.prod_w = $signed({1'b0, s0_ff.src_width}) * s0_ff.scale_x;
      s1_in.prod_h = $signed({1'b0, s0_ff.src_height}) * s0_ff.scale_y;
      s1_in.ox     = s0_ff.offset_x;
      s1_in.oy     = s0_ff.offset_y;
      s1_in.px     = s0_ff.pivot_x;
      s1_in.py     = s0_ff.pivot_y;
      s1_in.sx_neg = s0_ff.scale_x[15];
      s1_in.sy_neg = s0_ff.scale_y[15];
      // fold the angle into +-1/8 turn plus a quadrant
      ang_r        = {s0_ff.turn_angle, 16'h0000} + 32'h2000_0000;
      s1_in.quad   = ang_r[31:30];
      s1_in.cz     = $signed({2'b00, ang_r[29:0]}) - ANG_EIGHTH;
      s1_in.rot    = |s0_ff.turn_angle;
   end

   always_comb begin
      logic signed [30:0] oxe;
      logic signed [30:0] oye;
      oxe = 31'(s1_ff.ox);
      oye = 31'(s1_ff.oy);
      out_d.x_l  = s1_ff.sx_neg ? oxe - 31'(s1_ff.prod_w) : oxe;
      out_d.x_r  = s1_ff.sx_neg ? oxe : oxe + 31'(s1_ff.prod_w);
      out_d.y_t  = s1_ff.sy_neg ? oye - 31'(s1_ff.prod_h) : oye;
      out_d.y_b  = s1_ff.sy_neg ? oye : oye + 31'(s1_ff.prod_h);
      out_d.tx_l = 32'(out_d.x_l) - 32'(s1_ff.px);
      out_d.tx_r = 32'(out_d.x_r) - 32'(s1_ff.px);
      out_d.ty_t = 32'(out_d.y_t) - 32'(s1_ff.py);
      out_d.ty_b = 32'(out_d.y_b) - 32'(s1_ff.py);
      out_d.px   = s1_ff.px;
      out_d.py   = s1_ff.py;
      out_d.cx   = CORDIC_X0;
      out_d.cy   = 32'sd0;
      out_d.cz   = s1_ff.cz;
      out_d.quad = s1_ff.quad;
      out_d.rot  = s1_ff.rot;
      out_d.rem  = s1_ff.rem;
      out_d.qt   = '0;
      out_d.zero = s1_ff.zero;
      out_d.div_u = s1_ff.div_u;
      out_d.div_v = s1_ff.div_v;
      for (int n = 0; n < 4; n++) begin
         out_d.ovf[n] = s1_ff.rem[n] >= {((n < 2) ? s1_ff.div_u : s1_ff.div_v), 17'd0};
      end
   end

   assign out_v = s1_v_ff;

endmodule

[rtl/sqvs_iter.sv]
// Pipelined CORDIC rotation and four restoring dividers, two steps per stage.
module sqvs_iter import sqvs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_v,
   input  itm_type in_d,
   output logic    out_v,
   output itm_type out_d
);

   itm_type st_ff [ITER_STAGES];
   logic    v_ff  [ITER_STAGES];

   function automatic itm_type iter_steps(input itm_type d, input int k);
      itm_type            r;
      int                 st;
      int                 b;
      logic signed [31:0] nx;
      logic [29:0]        dsh;
      r = d;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         st = STEPS_PER_STAGE * k + j;
         if (st < CORDIC_N) begin
            if (!r.cz[31]) begin
               nx   = r.cx - (r.cy >>> st);
               r.cy = r.cy + (r.cx >>> st);
               r.cz = r.cz - atan_at(st);
            end else begin
               nx   = r.cx + (r.cy >>> st);
               r.cy = r.cy - (r.cx >>> st);
               r.cz = r.cz + atan_at(st);
            end
            r.cx = nx;
         end
         b = DIV_QBITS - 1 - st;
         if (b >= 0) begin
            for (int n = 0; n < 4; n++) begin
               dsh = {17'd0, ((n < 2) ? r.div_u : r.div_v)} << b;
               if (r.rem[n] >= dsh) begin
                  r.rem[n]       = r.rem[n] - dsh;
                  r.qt[n][b[4:0]] = 1'b1;
               end
            end
         end
      end
      return r;
   endfunction

   genvar k;
   generate
      for (k = 0; k < ITER_STAGES; k++) begin : g_stg
         itm_type cur;
         logic    cur_v;
         itm_type stg_in;
         if (k == 0) begin : g_first
            assign cur   = in_d;
            assign cur_v = in_v;
         end else begin : g_next
            assign cur   = st_ff[k-1];
            assign cur_v = v_ff[k-1];
         end
         assign stg_in = iter_steps(cur, k);
         always_ff @(posedge clock) begin
            if (reset) v_ff[k] <= 1'b0;
            else if (adv) v_ff[k] <= cur_v;
         end
         always_ff @(posedge clock) begin
            if (adv) st_ff[k] <= stg_in;
         end
      end
   endgenerate

   assign out_v = v_ff[ITER_STAGES-1];
   assign out_d = st_ff[ITER_STAGES-1];

endmodule

[rtl/sqvs_rotate.sv]
// Quadrant fix-up, rotation products, rounding, saturation and texture corner order.
module sqvs_rotate import sqvs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     ccw,
   input  logic     in_v,
   input  itm_type  in_d,
   output logic     out_v,
   output quad_type out_d
);

   typedef struct packed {
      logic signed [30:0] x_l;
      logic signed [30:0] x_r;
      logic signed [30:0] y_t;
      logic signed [30:0] y_b;
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic               rot;
      logic [3:0][16:0]   tex;
   } keep_type;

   typedef struct packed {
      logic signed [31:0] c;
      logic signed [31:0] s;
      logic signed [31:0] tx_l;
      logic signed [31:0] tx_r;
      logic signed [31:0] ty_t;
      logic signed [31:0] ty_b;
      keep_type           kp;
   } r0_type;

   typedef struct packed {
      logic signed [63:0] p_lc;
      logic signed [63:0] p_rc;
      logic signed [63:0] p_ls;
      logic signed [63:0] p_rs;
      logic signed [63:0] p_tc;
      logic signed [63:0] p_bc;
      logic signed [63:0] p_ts;
      logic signed [63:0] p_bs;
      keep_type           kp;
   } r1_type;

   typedef struct packed {
      logic [3:0][33:0] dx;
      logic [3:0][33:0] dy;
      keep_type         kp;
   } r2_type;

   localparam logic signed [63:0] RND_HALF = 64'sd536870912;

   r0_type   r0_ff, r0_in;
   r1_type   r1_ff, r1_in;
   r2_type   r2_ff, r2_in;
   quad_type r3_ff, r3_in;
   logic     r0_v_ff, r1_v_ff, r2_v_ff, r3_v_ff;

   function automatic logic [16:0] tex_fin(input logic [16:0] q, input logic z, input logic o);
      if (z) return 17'd0;
      if (o || (q > TEX_ONE)) return TEX_ONE;
      return q;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_v_ff <= 1'b0;
         r1_v_ff <= 1'b0;
         r2_v_ff <= 1'b0;
         r3_v_ff <= 1'b0;
      end else if (adv) begin
         r0_v_ff <= in_v;
         r1_v_ff <= r0_v_ff;
         r2_v_ff <= r1_v_ff;
         r3_v_ff <= r2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff <= r0_in;
         r1_ff <= r1_in;
         r2_ff <= r2_in;
         r3_ff <= r3_in;
      end
   end

   always_comb begin
      unique case (in_d.quad)
         2'd0: begin r0_in.c = in_d.cx;  r0_in.s = in_d.cy;  end
         2'd1: begin r0_in.c = -in_d.cy; r0_in.s = in_d.cx;  end
         2'd2: begin r0_in.c = -in_d.cx; r0_in.s = -in_d.cy; end
         default: begin r0_in.c = in_d.cy; r0_in.s = -in_d.cx; end
      endcase
      r0_in.tx_l  = in_d.tx_l;
      r0_in.tx_r  = in_d.tx_r;
      r0_in.ty_t  = in_d.ty_t;
      r0_in.ty_b  = in_d.ty_b;
      r0_in.kp.x_l = in_d.x_l;
      r0_in.kp.x_r = in_d.x_r;
      r0_in.kp.y_t = in_d.y_t;
      r0_in.kp.y_b = in_d.y_b;
      r0_in.kp.px  = in_d.px;
      r0_in.kp.py  = in_d.py;
      r0_in.kp.rot = in_d.rot;
      for (int n = 0; n < 4; n++) begin
         r0_in.kp.tex[n] = tex_fin(in_d.qt[n], in_d.zero[n], in_d.ovf[n]);
      end
   end

   always_comb begin
      r1_in.p_lc = r0_ff.tx_l * r0_ff.c;
      r1_in.p_rc = r0_ff.tx_r * r0_ff.c;
      r1_in.p_ls = r0_ff.tx_l * r0_ff.s;
      r1_in.p_rs = r0_ff.tx_r * r0_ff.s;
      r1_in.p_tc = r0_ff.ty_t * r0_ff.c;
      r1_in.p_bc = r0_ff.ty_b * r0_ff.c;
      r1_in.p_ts = r0_ff.ty_t * r0_ff.s;
      r1_in.p_bs = r0_ff.ty_b * r0_ff.s;
      r1_in.kp   = r0_ff.kp;
   end

   // corners 0 and 3 take the left column, 0 and 1 the top row
   always_comb begin
      logic               sel_l;
      logic               sel_t;
      logic signed [63:0] sum_x;
      logic signed [63:0] sum_y;
      for (int k = 0; k < 4; k++) begin
         sel_l = (k == 0) || (k == 3);
         sel_t = (k < 2);
         sum_x = (sel_l ? r1_ff.p_lc : r1_ff.p_rc) - (sel_t ? r1_ff.p_ts : r1_ff.p_bs) + RND_HALF;
         sum_y = (sel_l ? r1_ff.p_ls : r1_ff.p_rs) + (sel_t ? r1_ff.p_tc : r1_ff.p_bc) + RND_HALF;
         r2_in.dx[k] = 34'(sum_x >>> 30);
         r2_in.dy[k] = 34'(sum_y >>> 30);
      end
      r2_in.kp = r1_ff.kp;
   end

   always_comb begin
      logic               sel_l;
      logic               sel_t;
      logic signed [34:0] fx;
      logic signed [34:0] fy;
      for (int k = 0; k < 4; k++) begin
         sel_l = (k == 0) || (k == 3);
         sel_t = (k < 2);
         if (r2_ff.kp.rot) begin
            fx = 35'(r2_ff.kp.px) + 35'($signed(r2_ff.dx[k]));
            fy = 35'(r2_ff.kp.py) + 35'($signed(r2_ff.dy[k]));
         end else begin
            fx = 35'(sel_l ? r2_ff.kp.x_l : r2_ff.kp.x_r);
            fy = 35'(sel_t ? r2_ff.kp.y_t : r2_ff.kp.y_b);
         end
         r3_in.vx[k] = sat24(fx);
         r3_in.vy[k] = sat24(fy);
         r3_in.tu[k] = sel_l ? r2_ff.kp.tex[0] : r2_ff.kp.tex[1];
         r3_in.tv[k] = (sel_t ^ ccw) ? r2_ff.kp.tex[2] : r2_ff.kp.tex[3];
      end
   end

   assign out_v = r3_v_ff;
   assign out_d = r3_ff;

endmodule

[rtl/sqvs_serial.sv]
// Output register: holds one quad and hands out its four vertices one beat at a time.
module sqvs_serial import sqvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  quad_type           in_d,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_corner,
   output logic signed [23:0] rsp_vert_x,
   output logic signed [23:0] rsp_vert_y,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic               rsp_final_corner
);

   quad_type quad_ff;
   logic     busy_ff;
   logic [1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 2'd0;
      end else if (busy_ff && rsp_ready) begin
         if (cnt_ff == LAST_CORNER) busy_ff <= 1'b0;
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) quad_ff <= in_d;
   end

   assign free             = !busy_ff || (rsp_ready && (cnt_ff == LAST_CORNER));
   assign rsp_valid        = busy_ff;
   assign rsp_corner       = cnt_ff;
   assign rsp_vert_x       = $signed(quad_ff.vx[cnt_ff]);
   assign rsp_vert_y       = $signed(quad_ff.vy[cnt_ff]);
   assign rsp_tex_u        = quad_ff.tu[cnt_ff];
   assign rsp_tex_v        = quad_ff.tv[cnt_ff];
   assign rsp_final_corner = (cnt_ff == LAST_CORNER);

endmodule

[rtl/sprite_quad_vertex_setup.sv]
// A request passes the front, iteration and rotate stages, then the output register.
// Throughput: one request per cycle into the pipeline while req_ready is high; four vertex
//   beats per request leave one per cycle while rsp_ready is high, setting the sustained rate.
// A result stall halts all stages while the last stage holds a quad; nothing drops or repeats.
// Reset (synchronous, active high) empties all stages and sets 256 x 256 image, clockwise order.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [11:0]        req_src_left,
   input  logic [11:0]        req_src_top,
   input  logic [12:0]        req_src_width,
   input  logic [12:0]        req_src_height,
   input  logic signed [23:0] req_offset_x,
   input  logic signed [23:0] req_offset_y,
   input  logic signed [15:0] req_scale_x,
   input  logic signed [15:0] req_scale_y,
   input  logic signed [23:0] req_pivot_x,
   input  logic signed [23:0] req_pivot_y,
   input  logic [15:0]        req_turn_angle,
   // vertex channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_corner,
   output logic signed [23:0] rsp_vert_x,
   output logic signed [23:0] rsp_vert_y,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic               rsp_final_corner,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_data
);

   // configuration registers
   logic [12:0] img_w_ff;
   logic [12:0] img_h_ff;
   logic        ccw_ff;

   // pipeline wiring
   req_type  req_d;
   itm_type  fr_d, it_d;
   quad_type tail_d;
   logic     fr_v, it_v, tail_v;
   logic     ser_free;
   logic     pipe_adv;

   // Writes are always taken; an index beyond the list is ignored.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 13'd256;
         img_h_ff <= 13'd256;
         ccw_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_data;
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_data;
            CSR_CCW_WINDING:  ccw_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // The whole pipe steps together: whenever the last stage is empty or its
   // quad can move into the output register.
   assign pipe_adv  = !tail_v || ser_free;
   assign req_ready = pipe_adv;

   assign req_d.src_left   = req_src_left;
   assign req_d.src_top    = req_src_top;
   assign req_d.src_width  = req_src_width;
   assign req_d.src_height = req_src_height;
   assign req_d.offset_x   = req_offset_x;
   assign req_d.offset_y   = req_offset_y;
   assign req_d.scale_x    = req_scale_x;
   assign req_d.scale_y    = req_scale_y;
   assign req_d.pivot_x    = req_pivot_x;
   assign req_d.pivot_y    = req_pivot_y;
   assign req_d.turn_angle = req_turn_angle;

   // input register, products, dividends (two stages)
   sqvs_front u_front (
      .clock (clock),
      .reset (reset),
      .adv   (pipe_adv),
      .in_v  (req_valid),
      .in_d  (req_d),
      .img_w (img_w_ff),
      .img_h (img_h_ff),
      .out_v (fr_v),
      .out_d (fr_d)
   );

   // CORDIC and dividers, ITER_STAGES stages
   sqvs_iter u_iter (
      .clock (clock),
      .reset (reset),
      .adv   (pipe_adv),
      .in_v  (fr_v),
      .in_d  (fr_d),
      .out_v (it_v),
      .out_d (it_d)
   );

   // rotation, rounding, saturation, corner order (four stages)
   sqvs_rotate u_rotate (
      .clock (clock),
      .reset (reset),
      .adv   (pipe_adv),
      .ccw   (ccw_ff),
      .in_v  (it_v),
      .in_d  (it_d),
      .out_v (tail_v),
      .out_d (tail_d)
   );

   // output register, one vertex a beat
   sqvs_serial u_serial (
      .clock            (clock),
      .reset            (reset),
      .load             (tail_v && ser_free),
      .in_d             (tail_d),
      .free             (ser_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_corner       (rsp_corner),
      .rsp_vert_x       (rsp_vert_x),
      .rsp_vert_y       (rsp_vert_y),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_final_corner (rsp_final_corner)
   );

   // corners of a quad come out in order with no gap
   a_corner_seq : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_final_corner) |=>
         (rsp_valid && (rsp_corner == $past(rsp_corner) + 2'd1)))
      else $error("vertex beats out of order");

   // texture coordinates stay within 0..1
   a_tex_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_tex_u <= TEX_ONE) && (rsp_tex_v <= TEX_ONE)))
      else $error("texture coordinate above one");

   // a waiting quad is not lost while the pipe is held
   a_tail_hold : assert property (@(posedge clock) disable iff (reset)
      (tail_v && !pipe_adv) |=> tail_v)
      else $error("held quad dropped");

endmodule

[verif/tb_sprite_quad_vertex_setup.sv]
// Self-checking testbench for the sprite quad vertex setup block.
module tb_sprite_quad_vertex_setup;
   import sqvs_pkg::*;

   // one expected vertex beat
   typedef struct {
      logic [1:0]  corner;
      logic [23:0] vx;
      logic [23:0] vy;
      logic [16:0] tu;
      logic [16:0] tv;
      logic        fin;
   } vertex_type;

   localparam int WATCHDOG_LIMIT = 5000;  // idle limit for the watchdog below
   localparam int SETTLE_CYCLES  = 40;    // quiet time that drain() waits after the last vertex

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [11:0]        req_src_left = '0;
   logic [11:0]        req_src_top = '0;
   logic [12:0]        req_src_width = '0;
   logic [12:0]        req_src_height = '0;
   logic signed [23:0] req_offset_x = '0;
   logic signed [23:0] req_offset_y = '0;
   logic signed [15:0] req_scale_x = '0;
   logic signed [15:0] req_scale_y = '0;
   logic signed [23:0] req_pivot_x = '0;
   logic signed [23:0] req_pivot_y = '0;
   logic [15:0]        req_turn_angle = '0;

   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_corner;
   logic signed [23:0] rsp_vert_x;
   logic signed [23:0] rsp_vert_y;
   logic [16:0]        rsp_tex_u;
   logic [16:0]        rsp_tex_v;
   logic               rsp_final_corner;

   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [12:0]        csr_data = '0;

   // shadow copy of the registers
   logic [12:0] img_w_q = 13'd256;
   logic [12:0] img_h_q = 13'd256;
   logic        ccw_q   = 1'b0;

   vertex_type exp_vertices[$];
   int      errors = 0;
   int      reqs_sent = 0;
   int      verts_checked = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;

   sprite_quad_vertex_setup uut (.*);

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   function automatic logic [23:0] clamp_q15_8(input longint v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

   // rounded ratio num/div in Q1.16, clamped to 0..1
   function automatic logic [16:0] tex_ratio(input longint num, input longint dv);
      longint q;
      if (dv == 0) dv = 1;
      if (num <= 0) return 17'd0;
      q = ((num <<< 16) + (dv >>> 1)) / dv;
      if (q > 65536) return TEX_ONE;
      return q[16:0];
   endfunction

   // cos and sin in Q2.30 of a 32 bit turn angle; octant folded, then vectoring-free CORDIC
   task automatic cordic_sincos(input logic [31:0] ang, output longint c, output longint s);
      logic [31:0] r;
      longint      x, y, z, nx;
      r = ang + 32'h2000_0000;
      z = longint'(r[29:0]) - 64'sh2000_0000;
      x = 64'sh26DD3B6A;
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - longint'(ATAN_TURNS[i]);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + longint'(ATAN_TURNS[i]);
         end
         x = nx;
      end
      case (r[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   task automatic predict_quad(input req_type r);
      longint      xs[4], ys[4];
      longint      w, h, ox, oy, sx, sy, px, py, c, s, tx, ty, ih;
      logic [16:0] u0, u1, v0, v1;
      vertex_type     vt;
      w  = longint'(r.src_width);
      h  = longint'(r.src_height);
      ox = longint'(r.offset_x);
      oy = longint'(r.offset_y);
      sx = longint'(r.scale_x);
      sy = longint'(r.scale_y);
      px = longint'(r.pivot_x);
      py = longint'(r.pivot_y);
      // negative scale mirrors: corners swap sides
      if (sx >= 0) begin
         xs[0] = ox; xs[3] = ox; xs[1] = ox + w * sx; xs[2] = xs[1];
      end else begin
         xs[1] = ox; xs[2] = ox; xs[0] = ox - w * sx; xs[3] = xs[0];
      end
      if (sy >= 0) begin
         ys[0] = oy; ys[1] = oy; ys[3] = oy + h * sy; ys[2] = ys[3];
      end else begin
         ys[3] = oy; ys[2] = oy; ys[0] = oy - h * sy; ys[1] = ys[0];
      end
      if (r.turn_angle != 16'd0) begin
         cordic_sincos({r.turn_angle, 16'h0000}, c, s);
         for (int k = 0; k < 4; k++) begin
            tx = xs[k] - px;
            ty = ys[k] - py;
            xs[k] = px + ((tx * c - ty * s + 64'sh2000_0000) >>> 30);
            ys[k] = py + ((tx * s + ty * c + 64'sh2000_0000) >>> 30);
         end
      end
      ih = (img_h_q == 13'd0) ? 1 : longint'(img_h_q);
      u0 = tex_ratio(longint'(r.src_left), longint'(img_w_q));
      u1 = tex_ratio(longint'(r.src_left) + w, longint'(img_w_q));
      v0 = tex_ratio(ih - longint'(r.src_top), ih);
      v1 = tex_ratio(ih - longint'(r.src_top) - h, ih);
      for (int k = 0; k < 4; k++) begin
         vt.corner = 2'(k);
         vt.vx = clamp_q15_8(xs[k]);
         vt.vy = clamp_q15_8(ys[k]);
         vt.fin = (2'(k) == LAST_CORNER);
         // winding picks which corners get which v edge; u does not depend on it
         if (ccw_q) begin
            vt.tu = (k == 0 || k == 3) ? u0 : u1;
            vt.tv = (k == 2 || k == 3) ? v0 : v1;
         end else begin
            vt.tu = (k == 0 || k == 3) ? u0 : u1;
            vt.tv = (k == 0 || k == 1) ? v0 : v1;
         end
         exp_vertices.push_back(vt);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps in between
   // ---------------------------------------------------------------------------------------

   task automatic send_req(input req_type r);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         // about a quarter of bursts follow on with no gap at all
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_src_left   <= r.src_left;
      req_src_top    <= r.src_top;
      req_src_width  <= r.src_width;
      req_src_height <= r.src_height;
      req_offset_x   <= r.offset_x;
      req_offset_y   <= r.offset_y;
      req_scale_x    <= r.scale_x;
      req_scale_y    <= r.scale_y;
      req_pivot_x    <= r.pivot_x;
      req_pivot_y    <= r.pivot_y;
      req_turn_angle <= r.turn_angle;
      do @(posedge clock); while (!req_ready);
      predict_quad(r);
      reqs_sent++;
   endtask

   task automatic park_req();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   // wait for every outstanding vertex, then let the pipeline go quiet
   task automatic drain();
      park_req();
      while (exp_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_IMAGE_WIDTH:  img_w_q = val;
         CSR_IMAGE_HEIGHT: img_h_q = val;
         CSR_CCW_WINDING:  ccw_q   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [12:0] w, input logic [12:0] h, input logic ccw);
      drain();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_CCW_WINDING, {12'd0, ccw});
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------------------

   function automatic req_type plain_req();
      req_type r;
      r = '0;
      r.src_width  = 13'd16;
      r.src_height = 13'd16;
      r.scale_x    = 16'sd256;
      r.scale_y    = 16'sd256;
      return r;
   endfunction

   // well-formed sprite: any size, modest scales, positions well inside the range
   function automatic req_type sane_req();
      req_type r;
      r.src_left   = 12'($urandom_range(0, 4095));
      r.src_top    = 12'($urandom_range(0, 4095));
      r.src_width  = 13'($urandom_range(0, 4096));
      r.src_height = 13'($urandom_range(0, 4096));
      r.offset_x   = 24'($signed($urandom_range(0, 2097151)) - 1048576);
      r.offset_y   = 24'($signed($urandom_range(0, 2097151)) - 1048576);
      r.scale_x    = 16'($signed($urandom_range(0, 2047)) - 1024);
      r.scale_y    = 16'($signed($urandom_range(0, 2047)) - 1024);
      r.pivot_x    = 24'($signed($urandom_range(0, 2097151)) - 1048576);
      r.pivot_y    = 24'($signed($urandom_range(0, 2097151)) - 1048576);
      r.turn_angle = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
      return r;
   endfunction

   // anything the ports allow but sizes above 4096, saturation included
   function automatic req_type wild_req();
      req_type r;
      r.src_left   = 12'($urandom);
      r.src_top    = 12'($urandom);
      r.src_width  = 13'($urandom_range(0, 4096));
      r.src_height = 13'($urandom_range(0, 4096));
      r.offset_x   = 24'($urandom);
      r.offset_y   = 24'($urandom);
      r.scale_x    = 16'($urandom);
      r.scale_y    = 16'($urandom);
      r.pivot_x    = 24'($urandom);
      r.pivot_y    = 24'($urandom);
      r.turn_angle = 16'($urandom);
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   task automatic test_directed();
      req_type r;
      send_req(plain_req());                       // unit scale, no turn
      r = plain_req(); r.scale_x = -16'sd256; send_req(r);          // mirror x
      r = plain_req(); r.scale_y = -16'sd256; send_req(r);          // mirror y
      r = plain_req(); r.scale_x = -16'sd32768; r.scale_y = 16'sd32767; send_req(r);
      r = plain_req(); r.src_width = 13'd0; r.src_height = 13'd0; send_req(r);
      r = plain_req(); r.src_width = 13'd4096; r.src_height = 13'd4096;
      r.src_left = 12'd4095; r.src_top = 12'd4095; send_req(r);    // past the image
      r = plain_req(); r.turn_angle = 16'd1; send_req(r);
      r = plain_req(); r.turn_angle = 16'd16384; r.pivot_x = 24'sd2048; send_req(r);
      r = plain_req(); r.turn_angle = 16'd32768; r.pivot_y = -24'sd4096; send_req(r);
      r = plain_req(); r.turn_angle = 16'd49152; send_req(r);
      r = plain_req(); r.turn_angle = 16'd65535; send_req(r);
      r = plain_req(); r.turn_angle = 16'd8192; r.offset_x = 24'sd1000; send_req(r);
      // position overflow in both directions
      r = plain_req(); r.offset_x = 24'sh7FFFFF; r.offset_y = 24'sh7FFFFF;
      r.src_width = 13'd4096; r.src_height = 13'd4096;
      r.scale_x = 16'sd32767; r.scale_y = 16'sd32767; send_req(r);
      r.offset_x = 24'sh800000; r.offset_y = 24'sh800000;
      r.scale_x = -16'sd32768; r.scale_y = -16'sd32768; send_req(r);
      r.turn_angle = 16'd12345; r.pivot_x = 24'sh800000; r.pivot_y = 24'sh7FFFFF; send_req(r);
      r = plain_req(); r.offset_x = 24'sh7FFFFF; r.pivot_x = 24'sh800000;
      r.turn_angle = 16'd32768; send_req(r);
      r = '1; r.src_width = 13'd4096; r.src_height = 13'd4096; send_req(r);
      r = '0; send_req(r);
      drain();
   endtask

   // register extremes, zero image size and both windings
   task automatic test_register_settings();
      logic [12:0] ws[6] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd640, 13'd256};
      logic [12:0] hs[6] = '{13'd1, 13'd4096, 13'd0, 13'd100, 13'd480, 13'd256};
      for (int p = 0; p < 6; p++) begin
         set_config(ws[p], hs[p], p[0]);
         repeat (10) send_req(($urandom_range(0, 3) == 0) ? wild_req() : sane_req());
      end
      drain();
   endtask

   task automatic test_random_sprites();
      for (int n = 0; n < 240; n++) begin
         if (n % 80 == 0)
            set_config(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                       1'($urandom));
         send_req(($urandom_range(0, 4) == 0) ? wild_req() : sane_req());
      end
      drain();
   endtask

   // ---------------------------------------------------------------------------------------
   // Vertex receiver: stalls follow a random mode, redrawn as stall_cnt counts cycles
   // ---------------------------------------------------------------------------------------

   int stall_cnt = 0;
   int stall_mode = 0;
   int stall_left = 0;
   always @(negedge clock) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;                         // no back-pressure
         1: rsp_ready <= 1'($urandom);                 // coin toss
         2: rsp_ready <= (stall_cnt % 3 == 0);         // ready only while stall_cnt % 3 is zero
         default: begin                                // long stalls now and then
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 15);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Vertex checker
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      vertex_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (exp_vertices.size() == 0) begin
            $error("vertex beat with nothing expected: corner %0d", rsp_corner);
            errors++;
         end else begin
            e = exp_vertices.pop_front();
            verts_checked++;
            if (rsp_corner !== e.corner) begin
               $error("corner: expected %0d, got %0d", e.corner, rsp_corner); errors++;
            end
            if (rsp_vert_x !== e.vx) begin
               $error("vert_x: expected %h, got %h", e.vx, rsp_vert_x); errors++;
            end
            if (rsp_vert_y !== e.vy) begin
               $error("vert_y: expected %h, got %h", e.vy, rsp_vert_y); errors++;
            end
            if (rsp_tex_u !== e.tu) begin
               $error("tex_u: expected %h, got %h", e.tu, rsp_tex_u); errors++;
            end
            if (rsp_tex_v !== e.tv) begin
               $error("tex_v: expected %h, got %h", e.tv, rsp_tex_v); errors++;
            end
            if (rsp_final_corner !== e.fin) begin
               $error("final_corner: expected %0d, got %0d", e.fin, rsp_final_corner);
               errors++;
            end
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d vertices outstanding", exp_vertices.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_register_settings();
      test_random_sprites();
      if (exp_vertices.size() != 0) begin
         $error("%0d expected vertices never arrived", exp_vertices.size());
         errors++;
      end
      $display("covered %0d sprite requests and %0d vertex beats over several register settings",
               reqs_sent, verts_checked);
      $display("mismatches: %0d", errors);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
